// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// Depends on nothing; compiles to empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/bch_pkg.sv -----
// Types and constants of the barometric compensation block.
// Depends on nothing.
`default_nettype none
package bch_pkg;

    localparam int MUL_W = 64;
    localparam int DIV_W = 40;
    localparam int CFG_W = 24;

    localparam int SAMPLE_DIV_SHIFT = 19;
    localparam logic [2:0] SAMPLE_DIV_ODD = 3'd7;
    localparam int HEIGHT_DIV_SHIFT = 2;
    localparam logic [2:0] HEIGHT_DIV_ODD = 3'd3;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_TEMP_COEFFS  = 3'd0;
    localparam t_reg_idx REG_PRESS_OFFSET = 3'd1;
    localparam t_reg_idx REG_PRESS_LINEAR = 3'd2;
    localparam t_reg_idx REG_TEMP_CROSS   = 3'd3;
    localparam t_reg_idx REG_CROSS_LINEAR = 3'd4;
    localparam t_reg_idx REG_PRESS_SQUARE = 3'd5;
    localparam t_reg_idx REG_CROSS_SQUARE = 3'd6;
    localparam t_reg_idx REG_PRESS_CUBE   = 3'd7;

    typedef enum logic [2:0] {
        OP_TEMP    = 3'd0,
        OP_CUBE    = 3'd1,
        OP_SQUARE  = 3'd2,
        OP_LINEAR  = 3'd3,
        OP_TCROSS  = 3'd4,
        OP_TP      = 3'd5,
        OP_CSQUARE = 3'd6,
        OP_CROSS   = 3'd7
    } t_op;

    typedef struct packed {
        logic [23:0] raw_word;
    } t_in_item;

    typedef struct packed {
        logic               is_pressure;
        logic signed [39:0] pressure_q8;
        logic signed [31:0] temperature_q8;
        logic signed [39:0] height_q8;
        logic               height_valid;
    } t_out_item;

    typedef struct packed {
        logic                   done;
        logic                   neg;
        logic [2*MUL_W-1:0]     prod;
    } t_mul_res;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_res;

endpackage
`default_nettype wire

// ----- design/bch_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transaction.
// Depends on nothing; the payload type is given per instance.
`default_nettype none
interface bch_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/bch_mul.sv -----
// Serial shift-add multiplier: one multiplier bit per cycle, sign-magnitude.
// Depends on bch_pkg.
`default_nettype none
module bch_mul (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [63:0]       i_a,
    input  wire logic signed [63:0]       i_b,
    output bch_pkg::t_mul_res             o_res
);
    localparam int CW = $clog2(bch_pkg::MUL_W);

    logic [63:0]   r_hi, r_lo, r_mcand;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_neg;
    logic [63:0]   a_mag, b_mag;
    logic [64:0]   sum;

    always_comb begin
        a_mag = i_a[63] ? (~i_a + 64'd1) : i_a;
        b_mag = i_b[63] ? (~i_b + 64'd1) : i_b;
        sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 65'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(bch_pkg::MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi    <= '0;
            r_lo    <= a_mag;
            r_mcand <= b_mag;
            r_neg   <= i_a[63] ^ i_b[63];
        end else if (r_busy) begin
            r_hi <= sum[64:1];
            r_lo <= {sum[0], r_lo[63:1]};
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.prod = {r_hi, r_lo};
endmodule
`default_nettype wire

// ----- design/bch_cdiv.sv -----
// Serial restoring divider by a small odd constant, one quotient bit per cycle.
// Depends on bch_pkg.
`default_nettype none
module bch_cdiv (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bch_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [2:0]                 i_divisor,
    output bch_pkg::t_div_res               o_res
);
    localparam int CW = $clog2(bch_pkg::DIV_W);

    logic [bch_pkg::DIV_W-1:0] r_q;
    logic [2:0]                r_rem, r_d;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy, r_done;
    logic [3:0]                trial;
    logic                      ge;
    logic [2:0]                n_rem;

    always_comb begin
        trial = {r_rem, r_q[bch_pkg::DIV_W-1]};
        ge    = trial >= {1'b0, r_d};
        n_rem = ge ? 3'(trial - {1'b0, r_d}) : trial[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(bch_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[bch_pkg::DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_q;
endmodule
`default_nettype wire

// ----- design/baro_compensate_height_top.sv -----
// Barometric compensation top level: averages, calibration polynomials, height.
// Depends on bch_pkg, bch_stream_if, bch_mul, bch_cdiv and assert_macros.svh.
//
// Usage:
//   i_in carries one 24-bit sensor FIFO word per transaction; bit 0 set marks a
//   pressure sample, clear a temperature sample. o_out returns exactly one
//   result per input word: compensated pressure and temperature in 1/256 units,
//   the held height and the baseline flag.
//   Coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write them only while the block is idle, and the block itself
//   leaves this unenforced. Each write takes effect at the next clock edge.
//   The work is eight passes of a serial multiplier plus one or two serial
//   constant divisions, so one word is in flight at a time and i_in.ready is
//   high only between words.
//   A finished result sits in the output register; the next word is accepted
//   while it waits. If the receiver still stalls when the next result is ready,
//   the block holds that result internally until o_out.ready frees the register.
//   Reset (i_rst_n low at a clock edge) clears the coefficients, reloads both
//   averages, restarts the warm-up count and drops the baseline.
`default_nettype none
`include "assert_macros.svh"
module baro_compensate_height_top #(
    parameter int WARMUP_SAMPLES = 80,
    parameter int FRAC_BITS      = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bch_stream_if.sink                         i_in,
    bch_stream_if.source                       o_out,
    input  wire logic                          i_cfg_we,
    input  wire bch_pkg::t_reg_idx             i_cfg_idx,
    input  wire logic [bch_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam logic signed [31:0] PRESS_AVG_RST =
        32'(-(((64'd35135 << FRAC_BITS) + 64'd50000) / 64'd100000));
    localparam logic signed [31:0] TEMP_AVG_RST =
        32'(((64'd287 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV7 = 8'b0000_0010,
        ST_AVG  = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_POST = 8'b0001_0000,
        ST_BASE = 8'b0010_0000,
        ST_DIV3 = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    function automatic logic signed [63:0] rsr(input logic signed [63:0] x, input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? (~x + 64'd1) : x;
        r = (m >> s) + 64'(m[s-1]);
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        if (v > 64'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
        if (v < -64'sh80_0000_0000) return -40'sh80_0000_0000;
        return v[39:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] mulq_post(input logic [127:0] prod,
                                                     input logic neg);
        logic [127:0] p2;
        logic [63:0]  r;
        p2 = prod + (128'd1 << (FRAC_BITS - 1));
        r  = p2[FRAC_BITS +: 64];
        if ((p2 >> (64 + FRAC_BITS)) != 128'd0 || r[63]) return neg ? S64_MIN : S64_MAX;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] coef_q(input logic signed [63:0] c);
        return c <<< FRAC_BITS;
    endfunction

    t_state r_state;
    bch_pkg::t_op r_op;

    logic [23:0]        r_tcoef;
    logic signed [19:0] r_c00, r_c10;
    logic signed [15:0] r_c01, r_c11, r_c20, r_c21, r_c30;

    logic [23:0]        r_raw;
    logic signed [63:0] r_sample;
    logic signed [31:0] r_pavg, r_tavg;
    logic [6:0]         r_warm;
    logic               r_base_taken;
    logic signed [39:0] r_base, r_height, r_pq8;
    logic signed [31:0] r_tq8;
    logic signed [63:0] r_inner, r_acc, r_tp;
    logic               r_dneg, r_mul_go;
    bch_pkg::t_out_item r_out;
    logic               r_out_valid;

    bch_pkg::t_mul_res  mres;
    bch_pkg::t_div_res  dres;
    logic signed [63:0] op_a, op_b, plain, qres;
    logic               in_acc, div_start, out_load;
    logic [23:0]        raw_mag;
    logic [63:0]        u_val;
    logic signed [63:0] c0, c1, pav, tav, avg_sel, avg_sum;
    logic signed [40:0] diff;
    logic [40:0]        dmag, dv;
    logic [bch_pkg::DIV_W-1:0] div_in;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        c0  = 64'(signed'(r_tcoef[23:12]));
        c1  = 64'(signed'(r_tcoef[11:0]));
        pav = 64'(r_pavg);
        tav = 64'(r_tavg);
        raw_mag = i_in.payload.raw_word[23] ? (~i_in.payload.raw_word + 24'd1)
                                            : i_in.payload.raw_word;
        u_val = ((64'(raw_mag) << FRAC_BITS)
                + (64'(bch_pkg::SAMPLE_DIV_ODD) << (bch_pkg::SAMPLE_DIV_SHIFT - 1)))
                >> bch_pkg::SAMPLE_DIV_SHIFT;
        avg_sel = r_raw[0] ? pav : tav;
        avg_sum = (avg_sel <<< 3) - avg_sel + r_sample;
        diff = 41'(r_pq8) - 41'(r_base);
        dmag = diff[40] ? (~diff + 41'd1) : diff;
        dv   = (dmag + (41'(bch_pkg::HEIGHT_DIV_ODD) << (bch_pkg::HEIGHT_DIV_SHIFT - 1)))
               >> bch_pkg::HEIGHT_DIV_SHIFT;
        div_start = in_acc || ((r_state == ST_BASE) && r_base_taken);
        div_in    = (r_state == ST_IDLE) ? bch_pkg::DIV_W'(u_val) : dv[bch_pkg::DIV_W-1:0];
    end

    always_comb begin
        case (r_op)
            bch_pkg::OP_TEMP:    begin op_a = tav;  op_b = c1;                end
            bch_pkg::OP_CUBE:    begin op_a = pav;  op_b = 64'(r_c30);        end
            bch_pkg::OP_SQUARE:  begin op_a = pav;  op_b = r_inner;           end
            bch_pkg::OP_LINEAR:  begin op_a = pav;  op_b = r_inner;           end
            bch_pkg::OP_TCROSS:  begin op_a = tav;  op_b = 64'(r_c01);        end
            bch_pkg::OP_TP:      begin op_a = tav;  op_b = pav;               end
            bch_pkg::OP_CSQUARE: begin op_a = pav;  op_b = 64'(r_c21);        end
            default:             begin op_a = r_tp; op_b = r_inner;           end
        endcase
        plain = mres.neg ? -$signed(mres.prod[63:0]) : $signed(mres.prod[63:0]);
        qres  = mulq_post(mres.prod, mres.neg);
    end

    bch_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_res   (mres)
    );

    bch_cdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  ((r_state == ST_IDLE) ? bch_pkg::SAMPLE_DIV_ODD : bch_pkg::HEIGHT_DIV_ODD),
        .o_res      (dres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcoef <= '0;
            r_c00   <= '0;
            r_c10   <= '0;
            r_c01   <= '0;
            r_c11   <= '0;
            r_c20   <= '0;
            r_c21   <= '0;
            r_c30   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bch_pkg::REG_TEMP_COEFFS:  r_tcoef <= i_cfg_data;
                bch_pkg::REG_PRESS_OFFSET: r_c00   <= i_cfg_data[19:0];
                bch_pkg::REG_PRESS_LINEAR: r_c10   <= i_cfg_data[19:0];
                bch_pkg::REG_TEMP_CROSS:   r_c01   <= i_cfg_data[15:0];
                bch_pkg::REG_CROSS_LINEAR: r_c11   <= i_cfg_data[15:0];
                bch_pkg::REG_PRESS_SQUARE: r_c20   <= i_cfg_data[15:0];
                bch_pkg::REG_CROSS_SQUARE: r_c21   <= i_cfg_data[15:0];
                default:                   r_c30   <= i_cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op         <= bch_pkg::OP_TEMP;
            r_mul_go     <= 1'b0;
            r_pavg       <= PRESS_AVG_RST;
            r_tavg       <= TEMP_AVG_RST;
            r_warm       <= '0;
            r_base_taken <= 1'b0;
            r_base       <= '0;
            r_height     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_DIV7;
                    end
                end
                ST_DIV7: begin
                    if (dres.done) begin
                        r_state <= ST_AVG;
                    end
                end
                ST_AVG: begin
                    if (r_raw[0]) begin
                        r_pavg <= sat32(rsr(avg_sum, 3));
                    end else begin
                        r_tavg <= sat32(rsr(avg_sum, 3));
                    end
                    r_op     <= bch_pkg::OP_TEMP;
                    r_mul_go <= 1'b1;
                    r_state  <= ST_MUL;
                end
                ST_MUL: begin
                    if (mres.done) begin
                        if (r_op == bch_pkg::OP_CROSS) begin
                            r_state <= ST_POST;
                        end else begin
                            r_op     <= bch_pkg::t_op'(r_op + 3'd1);
                            r_mul_go <= 1'b1;
                        end
                    end
                end
                ST_POST: begin
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    if (r_base_taken) begin
                        r_state <= ST_DIV3;
                    end else begin
                        if (32'(r_warm) >= WARMUP_SAMPLES) begin
                            r_base       <= r_pq8;
                            r_base_taken <= 1'b1;
                        end else begin
                            r_warm <= r_warm + 7'd1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV3: begin
                    if (dres.done) begin
                        r_height <= r_dneg ? $signed(dres.quo) : -$signed(dres.quo);
                        r_state  <= ST_DONE;
                    end
                end
                default: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw <= i_in.payload.raw_word;
        end
        if ((r_state == ST_DIV7) && dres.done) begin
            r_sample <= r_raw[23] ? -$signed(64'(dres.quo)) : $signed(64'(dres.quo));
        end
        if ((r_state == ST_MUL) && mres.done) begin
            case (r_op)
                bch_pkg::OP_TEMP:    r_tq8 <= sat32(add_sat(c0 <<< 7, rsr(plain, FRAC_BITS - 8)));
                bch_pkg::OP_CUBE:    r_inner <= add_sat(coef_q(64'(r_c20)), plain);
                bch_pkg::OP_SQUARE:  r_inner <= add_sat(coef_q(64'(r_c10)), qres);
                bch_pkg::OP_LINEAR:  r_acc <= add_sat(coef_q(64'(r_c00)), qres);
                bch_pkg::OP_TCROSS:  r_acc <= add_sat(r_acc, plain);
                bch_pkg::OP_TP:      r_tp <= qres;
                bch_pkg::OP_CSQUARE: r_inner <= add_sat(coef_q(64'(r_c11)), plain);
                default:             r_acc <= add_sat(r_acc, qres);
            endcase
        end
        if (r_state == ST_POST) begin
            r_pq8 <= sat40(rsr(r_acc, FRAC_BITS - 8));
        end
        if (r_state == ST_BASE) begin
            r_dneg <= diff[40];
        end
        if (out_load) begin
            r_out.is_pressure    <= r_raw[0];
            r_out.pressure_q8    <= r_pq8;
            r_out.temperature_q8 <= r_tq8;
            r_out.height_q8      <= r_height;
            r_out.height_valid   <= r_base_taken;
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !i_in.ready, "accepted while busy")
    `ASSERT_CLK(a_base_sticky, i_clk, i_rst_n, r_base_taken |=> r_base_taken, "baseline dropped")
    `ASSERT_CLK(a_load_holds, i_clk, i_rst_n, (o_out.valid && !o_out.ready && !out_load) |=> $stable(o_out.payload), "result changed under stall")
    `ASSERT_CLK(a_warm_bound, i_clk, i_rst_n, 32'(r_warm) <= WARMUP_SAMPLES, "warm-up count overrun")
endmodule
`default_nettype wire

// ----- bench/baro_compensate_height_top_tb.sv -----
// Self-checking testbench for baro_compensate_height_top: random and directed
// sensor words, coefficient phases and back-pressure, checked by a bit-exact predictor.
// Depends on bch_pkg, bch_stream_if and the block's RTL.
`timescale 1ns / 1ps
module baro_compensate_height_top_tb;

    localparam int          WARMUP   = 80;
    localparam int          FB       = 24;
    localparam longint      CYC_MAX  = 6000000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    localparam int MODE_ZERO = 0;
    localparam int MODE_MAX  = 1;
    localparam int MODE_MIN  = 2;
    localparam int MODE_RAND = 3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    bch_pkg::t_reg_idx i_cfg_idx = bch_pkg::REG_TEMP_COEFFS;
    logic [bch_pkg::CFG_W-1:0] i_cfg_data = '0;

    bch_stream_if #(.t_payload(bch_pkg::t_in_item)) in_ch();
    bch_stream_if #(.t_payload(bch_pkg::t_out_item)) out_ch();

    baro_compensate_height_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [23:0] coeff [8];
    longint press_avg, temp_avg, base_press, height_hold;
    int     warm_cnt;
    bit     base_taken;

    bch_pkg::t_out_item expected_q[$];
    int  n_err = 0;
    bit  quiet = 0;
    bit  hold_req = 0;
    longint cycles = 0;

    function automatic logic [63:0] mag64(longint a);
        logic [63:0] r;
        r = a;
        if (a < 0) r = -r;
        return r;
    endfunction

    function automatic longint with_sign(logic [63:0] m, bit neg);
        if (m > POS_MAX) return neg ? I64_MIN : I64_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint shift_rnd(longint x, int s);
        logic [63:0] m;
        m = mag64(x);
        m = (m >> s) + ((m >> (s - 1)) & 64'd1);
        return with_sign(m, x < 0);
    endfunction

    function automatic longint div_rnd(longint x, logic [63:0] d);
        logic [63:0] m;
        logic [63:0] r;
        m = mag64(x);
        r = m % d;
        m = m / d + ((2 * r >= d) ? 64'd1 : 64'd0);
        return with_sign(m, x < 0);
    endfunction

    function automatic longint mul_frac(longint a, longint b);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] pr;
        bit neg;
        ua = mag64(a);
        ub = mag64(b);
        neg = (a < 0) != (b < 0);
        pr = ua * ub + (128'd1 << (FB - 1));
        if (pr[127:64+FB] != 0) return neg ? I64_MIN : I64_MAX;
        return with_sign(pr[63+FB:FB], neg);
    endfunction

    function automatic longint add_clip(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(I64_MAX)) return I64_MAX;
        if (s < 65'(I64_MIN)) return I64_MIN;
        return longint'(s);
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint coeff_s(bch_pkg::t_reg_idx i, int w);
        logic [63:0] v;
        v = coeff[i] & ((64'd1 << w) - 1);
        return longint'(v ^ (64'd1 << (w - 1))) - (longint'(1) <<< (w - 1));
    endfunction

    function automatic int reg_width(bch_pkg::t_reg_idx i);
        if (i == bch_pkg::REG_TEMP_COEFFS) return 24;
        if (i == bch_pkg::REG_PRESS_OFFSET || i == bch_pkg::REG_PRESS_LINEAR) return 20;
        return 16;
    endfunction

    function automatic bch_pkg::t_out_item compensate(logic [23:0] w);
        longint one, raw, sample, c0, c1, p, t, acc, inner, tq8, pq8;
        bch_pkg::t_out_item r;
        one = longint'(1) <<< FB;
        raw = longint'($signed(w));
        sample = div_rnd(raw * one, 64'd3670016);
        c0 = longint'($signed(coeff[bch_pkg::REG_TEMP_COEFFS][23:12]));
        c1 = longint'($signed(coeff[bch_pkg::REG_TEMP_COEFFS][11:0]));
        if (w[0]) press_avg = clip(shift_rnd(7 * press_avg + sample, 3), 32);
        else      temp_avg  = clip(shift_rnd(7 * temp_avg + sample, 3), 32);
        p = press_avg;
        t = temp_avg;
        tq8 = clip(c0 * 128 + shift_rnd(c1 * t, FB - 8), 32);
        inner = add_clip(coeff_s(bch_pkg::REG_PRESS_SQUARE, 16) * one,
                         coeff_s(bch_pkg::REG_PRESS_CUBE, 16) * p);
        inner = add_clip(coeff_s(bch_pkg::REG_PRESS_LINEAR, 20) * one, mul_frac(p, inner));
        acc = add_clip(coeff_s(bch_pkg::REG_PRESS_OFFSET, 20) * one, mul_frac(p, inner));
        acc = add_clip(acc, coeff_s(bch_pkg::REG_TEMP_CROSS, 16) * t);
        inner = add_clip(coeff_s(bch_pkg::REG_CROSS_LINEAR, 16) * one,
                         coeff_s(bch_pkg::REG_CROSS_SQUARE, 16) * p);
        acc = add_clip(acc, mul_frac(mul_frac(t, p), inner));
        pq8 = clip(shift_rnd(acc, FB - 8), 40);
        if (!base_taken) begin
            if (warm_cnt >= WARMUP) begin
                base_press = pq8;
                base_taken = 1;
            end else begin
                warm_cnt = (warm_cnt + 1) & 8'h7F;
            end
        end else begin
            height_hold = clip(-div_rnd(pq8 - base_press, 64'd12), 40);
        end
        r.is_pressure    = w[0];
        r.pressure_q8    = pq8[39:0];
        r.temperature_q8 = tq8[31:0];
        r.height_q8      = height_hold[39:0];
        r.height_valid   = base_taken;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        bch_pkg::t_out_item e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.payload;
            if (expected_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result %h", $realtime, a);
            end else begin
                e = expected_q.pop_front();
                if (a.is_pressure !== e.is_pressure) begin
                    n_err++;
                    $display("%0t: is_pressure exp %0d got %0d", $realtime,
                             e.is_pressure, a.is_pressure);
                end
                if (a.pressure_q8 !== e.pressure_q8) begin
                    n_err++;
                    $display("%0t: pressure_q8 exp %0d got %0d", $realtime,
                             e.pressure_q8, a.pressure_q8);
                end
                if (a.temperature_q8 !== e.temperature_q8) begin
                    n_err++;
                    $display("%0t: temperature_q8 exp %0d got %0d", $realtime,
                             e.temperature_q8, a.temperature_q8);
                end
                if (a.height_q8 !== e.height_q8) begin
                    n_err++;
                    $display("%0t: height_q8 exp %0d got %0d", $realtime,
                             e.height_q8, a.height_q8);
                end
                if (a.height_valid !== e.height_valid) begin
                    n_err++;
                    $display("%0t: height_valid exp %0d got %0d", $realtime,
                             e.height_valid, a.height_valid);
                end
            end
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_req = 0;
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [23:0] w);
        bch_pkg::t_in_item it;
        it.raw_word = w;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(compensate(w));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_coeffs(int mode);
        logic [23:0] v;
        int w;
        for (int i = 0; i < 8; i++) begin
            w = reg_width(bch_pkg::t_reg_idx'(i));
            case (mode)
                MODE_ZERO: v = '0;
                MODE_MAX:  v = (i == 0) ? 24'h7FF7FF : (24'd1 << (w - 1)) - 24'd1;
                MODE_MIN:  v = (i == 0) ? 24'h800800 : (24'd1 << (w - 1));
                default:   v = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            // junk above the register width must be dropped
            if (w < 24) v = v | (24'($urandom) & ~((24'd1 << w) - 24'd1));
            i_cfg_we <= 1'b1;
            i_cfg_idx <= bch_pkg::t_reg_idx'(i);
            i_cfg_data <= v;
            @(posedge i_clk);
            coeff[i] = v & ((24'd1 << w) - 24'd1);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_word(24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic test_field_extremes();
        logic [23:0] words [12];
        words = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h7FFFFE, 24'h800000,
                  24'h800001, 24'hFFFFFF, 24'hFFFFFE, 24'hAAAAAA, 24'h555555,
                  24'h7FFFFF, 24'h800001};
        foreach (words[i]) send_word(words[i]);
        drain();
    endtask

    task automatic test_zero_baseline();
        while (!base_taken) send_word(24'($urandom_range(0, 24'hFFFFFF)));
        send_random(4);
        drain();
    endtask

    task automatic test_coeff_extremes();
        write_coeffs(MODE_MAX);
        for (int i = 0; i < 30; i++) send_word(24'h7FFFFF);
        for (int i = 0; i < 30; i++) send_word(24'h800001);
        send_random(20);
        drain();
        write_coeffs(MODE_MIN);
        for (int i = 0; i < 30; i++) send_word(24'h800000);
        for (int i = 0; i < 30; i++) send_word(24'h7FFFFE);
        send_random(20);
        drain();
    endtask

    task automatic test_backpressure();
        write_coeffs(MODE_RAND);
        hold_req = 1;
        send_random(8);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++) begin
            write_coeffs(MODE_RAND);
            send_random(200);
            drain();
        end
    endtask

    task automatic test_no_idle();
        quiet = 1;
        write_coeffs(MODE_RAND);
        send_random(150);
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        foreach (coeff[i]) coeff[i] = '0;
        press_avg = -longint'(((64'd35135 << FB) + 64'd50000) / 64'd100000);
        temp_avg = longint'(((64'd287 << FB) + 64'd500) / 64'd1000);
        warm_cnt = 0;
        base_taken = 0;
        base_press = 0;
        height_hold = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_zero_baseline();
        test_coeff_extremes();
        test_backpressure();
        test_random_phases();
        test_no_idle();
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
